### hw/rtl/sparse_set_table_defines.svh
// ============================================================================
// Sparse set table assertion macros
// Shared wrappers for the concurrent checks of the block.
// ============================================================================
`ifndef SPARSE_SET_TABLE_DEFINES_SVH
`define SPARSE_SET_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define SST_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define SST_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/sst_pkg.sv
// ============================================================================
// Sparse set table package
// Sizes, codes and record layouts shared by the sparse set table modules.
// ============================================================================
`timescale 1ns / 1ps

package sst_pkg;

    // Table sizes.
    localparam int INDEX_SPACE    = 4096;
    localparam int DENSE_CAPACITY = 4096;
    localparam int IDX_W          = $clog2(INDEX_SPACE);

    // Field widths of a request and a result.
    localparam int CMD_W    = 2;
    localparam int ID_W     = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 12;
    localparam int CNT_W    = 13;

    // Request kinds; the unused code behaves as a look up.
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2
    } cmd_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_PRESENT = 3'd1,
        ST_ABSENT  = 3'd2,
        ST_FULL    = 3'd3,
        ST_DIFFERS = 3'd4
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SPARSE,
        S_DENSE,
        S_MOVE
    } state_t;

    // One sparse table entry.
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } sparse_entry_t;

    localparam int SPARSE_W = $bits(sparse_entry_t);

    // One result, status in the lowest bits.
    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [SLOT_W-1:0] moved_from;
        logic              moved;
        logic [SLOT_W-1:0] slot;
        status_t           status;
    } result_t;

    localparam int RESULT_W    = $bits(result_t);
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

### hw/rtl/sst_ram.sv
// ============================================================================
// Sparse set table RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ============================================================================
`timescale 1ns / 1ps

module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/sparse_set_table.sv
// ============================================================================
// Sparse set table
// Maps 32-bit entity ids to dense slots with add, look up and swap-remove.
// ============================================================================
//
// Channel   Direction  Signals                     Moves
// s_*       in         tvalid tready tdata tuser   one request: command, entity_id
// m_*       out        tvalid tready tdata         one result per request
//
// A request passes the idle step that accepts it, the sparse RAM read and the
// dense RAM read (S_IDLE, S_SPARSE, S_DENSE); its result is loaded into the
// output register at the end of the dense step. A remove that moves the last
// entry adds an S_MOVE step that repoints the moved id and loads the result.
// Both RAMs have a registered read; the sparse RAM and then the dense RAM are read back to back.
// After reset a clearing pass writes every sparse entry to empty, with
// s_tready low. A result waiting in the output register does
// not block acceptance; the sequencer holds in its last step, with no RAM
// write done, until the output register frees.
`timescale 1ns / 1ps

module sparse_set_table (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [sst_pkg::ID_W-1:0]             s_tdata,   // entity_id
    input  logic [sst_pkg::CMD_W-1:0]            s_tuser,   // command
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // status, slot, moved, moved_from, count, zero fill
    output logic [sst_pkg::OUT_TDATA_W-1:0]      m_tdata
);

    localparam int SLOT_W = sst_pkg::SLOT_W;
    localparam int CNT_W  = sst_pkg::CNT_W;
    localparam int IDX_W  = sst_pkg::IDX_W;
    localparam int PAD_W  = sst_pkg::OUT_TDATA_W - sst_pkg::RESULT_W;

    sst_pkg::state_t         state_reg, state_next;
    logic [IDX_W-1:0]        clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [sst_pkg::CMD_W-1:0] cmd_reg;
    logic [sst_pkg::ID_W-1:0]  id_reg;
    logic [sst_pkg::ID_W-1:0]  last_id_reg;
    logic                    m_tvalid_reg;
    sst_pkg::result_t        result_reg;

    logic                    accept;
    logic                    out_free;
    logic                    out_load;
    sst_pkg::result_t        out_result;

    logic                    sparse_we;
    logic [IDX_W-1:0]        sparse_waddr;
    sst_pkg::sparse_entry_t  sparse_wdata;
    logic [sst_pkg::SPARSE_W-1:0] sparse_rdata;
    sst_pkg::sparse_entry_t  entry;

    logic                    dense_we;
    logic [SLOT_W-1:0]       dense_waddr;
    logic [sst_pkg::ID_W-1:0]  dense_wdata;
    logic                    dense_re;
    logic [SLOT_W-1:0]       dense_raddr;
    logic [sst_pkg::ID_W-1:0]  dense_rdata;

    logic [SLOT_W-1:0]       last_slot;
    logic                    present_pre;
    logic                    hit;
    logic                    full;
    logic                    do_move;

    // Handshake.
    assign s_tready = (state_reg == sst_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, result_reg};

    // Sparse table: valid bit and dense slot per index.
    sst_ram #(
        .WIDTH(sst_pkg::SPARSE_W),
        .DEPTH(sst_pkg::INDEX_SPACE)
    ) u_sparse_ram (
        .clk  (clk),
        .we   (sparse_we),
        .waddr(sparse_waddr),
        .wdata(sparse_wdata),
        .re   (accept),
        .raddr(s_tdata[IDX_W-1:0]),
        .rdata(sparse_rdata)
    );

    assign entry = sparse_rdata;

    // Dense list of full ids.
    sst_ram #(
        .WIDTH(sst_pkg::ID_W),
        .DEPTH(sst_pkg::DENSE_CAPACITY)
    ) u_dense_ram (
        .clk  (clk),
        .we   (dense_we),
        .waddr(dense_waddr),
        .wdata(dense_wdata),
        .re   (dense_re),
        .raddr(dense_raddr),
        .rdata(dense_rdata)
    );

    // The last dense entry is read on acceptance, the entry's own slot next.
    assign last_slot   = SLOT_W'(count_reg - CNT_W'(1));
    assign dense_re    = accept || (state_reg == sst_pkg::S_SPARSE);
    assign dense_raddr = accept ? last_slot : entry.slot;

    // Lookup outcome, valid in the dense step.
    assign present_pre = entry.valid && ({1'b0, entry.slot} < count_reg);
    assign hit         = present_pre && (dense_rdata == id_reg);
    assign full        = (count_reg == CNT_W'(sst_pkg::DENSE_CAPACITY));
    assign do_move     = (cmd_reg == sst_pkg::CMD_REMOVE) && hit && (entry.slot != last_slot);

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sst_pkg::S_CLEAR;
            clr_addr_reg <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            count_reg    <= count_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= s_tuser;
            id_reg  <= s_tdata;
        end
        if (state_reg == sst_pkg::S_SPARSE)
        begin
            last_id_reg <= dense_rdata;
        end
        if (out_load)
        begin
            result_reg <= out_result;
        end
    end

    // Sequencer: next state, RAM writes and result.
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        count_next    = count_reg;
        sparse_we     = 1'b0;
        sparse_waddr  = id_reg[IDX_W-1:0];
        sparse_wdata  = '0;
        dense_we      = 1'b0;
        dense_waddr   = entry.slot;
        dense_wdata   = last_id_reg;
        out_load      = 1'b0;
        out_result.status     = sst_pkg::ST_OK;
        out_result.slot       = entry.slot;
        out_result.moved      = 1'b0;
        out_result.moved_from = '0;
        out_result.count      = count_reg;

        unique case (state_reg)
            sst_pkg::S_CLEAR:
            begin
                sparse_we     = 1'b1;
                sparse_waddr  = clr_addr_reg;
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == IDX_W'(sst_pkg::INDEX_SPACE - 1))
                begin
                    state_next = sst_pkg::S_IDLE;
                end
            end

            sst_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = sst_pkg::S_SPARSE;
                end
            end

            sst_pkg::S_SPARSE:
            begin
                state_next = sst_pkg::S_DENSE;
            end

            sst_pkg::S_DENSE:
            begin
                if (do_move)
                begin
                    // Free the entry and fill its slot with the last id.
                    sparse_we  = 1'b1;
                    dense_we   = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    state_next = sst_pkg::S_MOVE;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = sst_pkg::S_IDLE;
                    if (present_pre && !hit)
                    begin
                        out_result.status = sst_pkg::ST_DIFFERS;
                    end
                    else if (cmd_reg == sst_pkg::CMD_ADD)
                    begin
                        if (hit)
                        begin
                            out_result.status = sst_pkg::ST_PRESENT;
                        end
                        else if (full)
                        begin
                            out_result.status = sst_pkg::ST_FULL;
                            out_result.slot   = '0;
                        end
                        else
                        begin
                            // Append at the end of the dense list.
                            sparse_we          = 1'b1;
                            sparse_wdata.valid = 1'b1;
                            sparse_wdata.slot  = SLOT_W'(count_reg);
                            dense_we           = 1'b1;
                            dense_waddr        = SLOT_W'(count_reg);
                            dense_wdata        = id_reg;
                            count_next         = count_reg + CNT_W'(1);
                            out_result.slot    = SLOT_W'(count_reg);
                            out_result.count   = count_reg + CNT_W'(1);
                        end
                    end
                    else if (!hit)
                    begin
                        out_result.status = sst_pkg::ST_ABSENT;
                        out_result.slot   = '0;
                    end
                    else if (cmd_reg == sst_pkg::CMD_REMOVE)
                    begin
                        // Removing the last slot needs no move.
                        sparse_we        = 1'b1;
                        count_next       = count_reg - CNT_W'(1);
                        out_result.count = count_reg - CNT_W'(1);
                    end
                end
            end

            sst_pkg::S_MOVE:
            begin
                if (out_free)
                begin
                    // Repoint the moved id at its new slot.
                    sparse_we             = 1'b1;
                    sparse_waddr          = last_id_reg[IDX_W-1:0];
                    sparse_wdata.valid    = 1'b1;
                    sparse_wdata.slot     = entry.slot;
                    out_load              = 1'b1;
                    out_result.moved      = 1'b1;
                    out_result.moved_from = SLOT_W'(count_reg);
                    state_next            = sst_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = sst_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/sst_checker.sv
// ============================================================================
// Sparse set table checker
// Port-level checks on the request and result streams of the sparse set table.
// ============================================================================
`timescale 1ns / 1ps
`include "sparse_set_table_defines.svh"

module sst_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [sst_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    localparam logic [sst_pkg::CNT_W-1:0] FULL_COUNT =
        sst_pkg::CNT_W'(sst_pkg::DENSE_CAPACITY);

    sst_pkg::result_t res;
    logic             out_stall;
    logic             move_shape_ok;
    logic             fail_quiet_ok;

    assign res           = m_tdata[sst_pkg::RESULT_W-1:0];
    assign out_stall     = m_tvalid && !m_tready;
    assign move_shape_ok = (res.status == sst_pkg::ST_OK)
                        && (res.moved_from > res.slot)
                        && (res.count < FULL_COUNT);
    assign fail_quiet_ok = (res.status == sst_pkg::ST_OK)
                        || (!res.moved && (res.moved_from == '0));

    // A stalled result stays put.
    `SST_ASSERT_NXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "stalled result changed")

    // A move only follows a successful remove, from a higher slot, leaving the list below full.
    `SST_ASSERT_IMP(a_move_shape, m_tvalid && res.moved, move_shape_ok, "bad move report")

    // Failed requests report no move and no former slot.
    `SST_ASSERT_IMP(a_fail_quiet, m_tvalid, fail_quiet_ok, "move reported on a failed request")

    // The occupied count never exceeds the dense capacity.
    `SST_ASSERT_IMP(a_count_cap, m_tvalid, res.count <= FULL_COUNT, "count beyond capacity")

    // Only one request is in flight at a time.
    `SST_ASSERT_NXT(a_in_single, s_tvalid && s_tready, !s_tready, "request taken while busy")

endmodule

bind sparse_set_table sst_checker u_sst_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

### tb/tb_sparse_set_table.sv
// ============================================================================
// Sparse set table testbench
// Drives add, look up and remove requests into the sparse set table, predicts
// each result from a private copy of the sparse table and dense list, and
// checks every result field in order under random sender gaps and receiver
// stalls, including one long receiver hold-off that backs the block up.
// ============================================================================
`timescale 1ns / 1ps

module tb_sparse_set_table;

    localparam int ID_W           = sst_pkg::ID_W;
    localparam int CMD_W          = sst_pkg::CMD_W;
    localparam int IDX_W          = sst_pkg::IDX_W;
    localparam int SLOT_W         = sst_pkg::SLOT_W;
    localparam int CNT_W          = sst_pkg::CNT_W;
    localparam int RESULT_W       = sst_pkg::RESULT_W;
    localparam int OUT_TDATA_W    = sst_pkg::OUT_TDATA_W;
    localparam int INDEX_SPACE    = sst_pkg::INDEX_SPACE;
    localparam int DENSE_CAPACITY = sst_pkg::DENSE_CAPACITY;

    typedef sst_pkg::result_t result_t;

    // The fourth command code is not in the package; it behaves as a look up.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int FILL_ITEMS     = 512;
    localparam int RANDOM_ITEMS   = 700;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_SLACK    = 16;
    // Covers the clearing pass after reset and the long receiver hold-off.
    localparam int WATCHDOG_LIMIT = 20000;

    // Clock and reset.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Block ports.
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [ID_W-1:0]        s_tdata  = '0;    // entity_id
    logic [CMD_W-1:0]       s_tuser  = '0;    // command
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // status, slot, moved, moved_from, count, zero fill
    logic [OUT_TDATA_W-1:0] m_tdata;

    sparse_set_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Private copy of the set: sparse entries, dense ids and the occupancy.
    logic              sparse_valid [INDEX_SPACE] = '{default: 1'b0};
    logic [SLOT_W-1:0] sparse_slot  [INDEX_SPACE] = '{default: '0};
    logic [ID_W-1:0]   dense_id     [DENSE_CAPACITY];
    logic [CNT_W-1:0]  occupied     = '0;

    result_t pending_results [$];
    int      mismatch_count = 0;

    // Sender pacing state.
    bit pacing_on   = 1'b1;
    int burst_left  = 0;
    int steady_left = 0;

    // Receiver hold-off requests, counted so the receiver can see new ones.
    int hold_requests = 0;

    // Applies one request to the private set and returns the result it gives.
    function automatic result_t sparse_set_apply(input logic [CMD_W-1:0] cmd,
                                                 input logic [ID_W-1:0] id);
        logic [IDX_W-1:0]  idx;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] last;
        logic [ID_W-1:0]   mover;
        logic              present;
        result_t           r;
        idx     = id[IDX_W-1:0];
        slot    = sparse_slot[idx];
        present = sparse_valid[idx] && (slot < occupied);
        r       = '0;
        r.status = sst_pkg::ST_OK;
        if (present && dense_id[slot] != id)
        begin
            // Another id with the same index owns the entry.
            r.status = sst_pkg::ST_DIFFERS;
            r.slot   = slot;
        end
        else if (cmd == sst_pkg::CMD_ADD)
        begin
            if (present)
            begin
                r.status = sst_pkg::ST_PRESENT;
                r.slot   = slot;
            end
            else if (occupied >= DENSE_CAPACITY)
            begin
                r.status = sst_pkg::ST_FULL;
            end
            else
            begin
                slot              = occupied[SLOT_W-1:0];
                dense_id[slot]    = id;
                sparse_valid[idx] = 1'b1;
                sparse_slot[idx]  = slot;
                occupied          = occupied + 1'b1;
                r.slot            = slot;
            end
        end
        else if (!present)
        begin
            r.status = sst_pkg::ST_ABSENT;
        end
        else if (cmd == sst_pkg::CMD_REMOVE)
        begin
            // Swap-remove: the last dense entry fills the freed slot.
            last              = SLOT_W'(occupied - 1'b1);
            sparse_valid[idx] = 1'b0;
            sparse_slot[idx]  = '0;
            occupied          = occupied - 1'b1;
            r.slot            = slot;
            if (slot != last)
            begin
                mover                           = dense_id[last];
                dense_id[slot]                  = mover;
                sparse_valid[mover[IDX_W-1:0]]  = 1'b1;
                sparse_slot[mover[IDX_W-1:0]]   = slot;
                r.moved                         = 1'b1;
                r.moved_from                    = last;
            end
        end
        else
        begin
            r.slot = slot;
        end
        r.count = occupied;
        return r;
    endfunction

    // Reports one mismatching result field.
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Random bursts and gaps on the request side, with stretches of no gaps.
    task automatic pace_sender();
        if (!pacing_on)
            return;
        if (steady_left > 0)
        begin
            steady_left--;
        end
        else if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(0, 15);
            if ($urandom_range(0, 4) == 0)
                steady_left = $urandom_range(50, 200);
        end
    endtask

    // Offers one request, waits for it to be taken and records its result.
    // Called right after a rising edge; leaves tvalid high for a next request unless pacing adds a gap.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= id;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(sparse_set_apply(cmd, id));
        pace_sender();
    endtask

    // Ends a test with the request side idle.
    task automatic release_sender();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // Extremes of the id, every command and every status but ST_FULL.
    task automatic test_basic_commands();
        logic [ID_W-1:0] id_zero;
        logic [ID_W-1:0] id_ones;
        logic [ID_W-1:0] id_alias;
        logic [ID_W-1:0] id_other;
        id_zero  = 32'h0000_0000;
        id_ones  = 32'hFFFF_FFFF;
        id_alias = 32'h0000_1000;   // same sparse index as id_zero
        id_other = 32'h5A5A_A123;
        send_request(sst_pkg::CMD_ADD, id_zero);
        send_request(sst_pkg::CMD_ADD, id_ones);
        send_request(sst_pkg::CMD_ADD, id_zero);        // already present
        send_request(sst_pkg::CMD_LOOKUP, id_zero);
        send_request(sst_pkg::CMD_LOOKUP, id_ones);
        send_request(sst_pkg::CMD_LOOKUP, id_other);    // absent
        send_request(sst_pkg::CMD_REMOVE, id_other);    // absent
        send_request(sst_pkg::CMD_ADD, id_alias);       // stored id differs
        send_request(sst_pkg::CMD_LOOKUP, id_alias);
        send_request(sst_pkg::CMD_REMOVE, id_alias);
        send_request(CMD_UNUSED, id_zero);              // unused code acts as a look up
        send_request(CMD_UNUSED, id_other);
        send_request(sst_pkg::CMD_ADD, id_other);
        send_request(sst_pkg::CMD_REMOVE, id_other);    // last slot, nothing moves
        send_request(sst_pkg::CMD_ADD, id_other);
        send_request(sst_pkg::CMD_REMOVE, id_zero);     // last entry moves into slot 0
        send_request(sst_pkg::CMD_LOOKUP, id_other);
        send_request(sst_pkg::CMD_REMOVE, id_ones);
        send_request(sst_pkg::CMD_REMOVE, id_other);    // set becomes empty
        send_request(sst_pkg::CMD_REMOVE, id_zero);
        send_request(sst_pkg::CMD_LOOKUP, id_zero);
        send_request(sst_pkg::CMD_ADD, id_alias);       // index is free again
        release_sender();
    endtask

    // Loads a large part of the dense list, pokes it, then empties it at random.
    task automatic test_fill_and_drain();
        int              order [INDEX_SPACE];
        int              j;
        int              tmp;
        logic [ID_W-1:0] rnd;
        logic [ID_W-1:0] id;
        for (int i = 0; i < INDEX_SPACE; i++)
            order[i] = i;
        for (int i = INDEX_SPACE - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < FILL_ITEMS; i++)
        begin
            if (!(sparse_valid[order[i]] && sparse_slot[order[i]] < occupied))
            begin
                rnd = $urandom();
                send_request(sst_pkg::CMD_ADD, {rnd[ID_W-1:IDX_W], IDX_W'(order[i])});
            end
        end
        // Random adds, adds of stored ids and look ups on the loaded set.
        for (int i = 0; i < 6; i++)
        begin
            rnd = $urandom();
            send_request(sst_pkg::CMD_ADD, rnd);
            id = dense_id[$urandom_range(0, occupied - 1)];
            send_request(sst_pkg::CMD_ADD, id);
            send_request(sst_pkg::CMD_LOOKUP, id);
        end
        while (occupied != 0)
        begin
            id = dense_id[$urandom_range(0, occupied - 1)];
            if ($urandom_range(0, 7) == 0)
                send_request(sst_pkg::CMD_LOOKUP, id);
            send_request(sst_pkg::CMD_REMOVE, id);
        end
        rnd = $urandom();
        send_request(sst_pkg::CMD_REMOVE, rnd);
        release_sender();
    endtask

    // The receiver holds off while requests keep coming, so the input stalls.
    task automatic test_output_backpressure();
        logic [ID_W-1:0] rnd;
        pacing_on = 1'b0;
        hold_requests <= hold_requests + 1;
        for (int i = 0; i < 40; i++)
        begin
            rnd = $urandom();
            send_request(($urandom_range(0, 2) == 0) ? sst_pkg::CMD_LOOKUP : sst_pkg::CMD_ADD,
                         rnd);
        end
        pacing_on = 1'b1;
        release_sender();
    endtask

    // Mostly well-formed traffic on a small set, plus aliases and noise.
    task automatic test_random_mix();
        int               pick;
        int               add_share;
        logic [ID_W-1:0]  rnd;
        logic [ID_W-1:0]  existing;
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  id;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick      = $urandom_range(0, 99);
            rnd       = $urandom();
            existing  = rnd;
            if (occupied != 0)
                existing = dense_id[$urandom_range(0, occupied - 1)];
            add_share = (occupied < 48) ? 40 : 15;
            if (occupied == 0 || pick < add_share)
            begin
                cmd = sst_pkg::CMD_ADD;
                id  = rnd;
            end
            else if (pick < 65)
            begin
                cmd = sst_pkg::CMD_REMOVE;
                id  = existing;
            end
            else if (pick < 80)
            begin
                cmd = sst_pkg::CMD_LOOKUP;
                id  = existing;
            end
            else if (pick < 88)
            begin
                // Same sparse index as a stored id, different upper bits.
                cmd = CMD_W'($urandom_range(0, 3));
                id  = {rnd[ID_W-1:IDX_W], existing[IDX_W-1:0]};
            end
            else if (pick < 93)
            begin
                cmd = sst_pkg::CMD_ADD;
                id  = existing;
            end
            else
            begin
                cmd = CMD_W'($urandom_range(0, 3));
                id  = rnd;
            end
            send_request(cmd, id);
        end
        release_sender();
    endtask

    // Result side: stall modes that change now and then, plus long hold-offs.
    int       hold_left   = 0;
    int       hold_seen   = 0;
    int       stall_mode  = 0;
    bit [8:0] stall_phase = '0;

    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1'b1;
        if (stall_phase == '0)
            stall_mode <= $urandom_range(0, 2);
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_requests)
        begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= (stall_phase[1:0] == 2'd0);
            endcase
        end
    end

    // Compares each result taken from the block with the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[RESULT_W-1:0]);
            if (pending_results.size() == 0)
            begin
                $error("result with none expected: status %0d slot %0d count %0d",
                       got.status, got.slot, got.count);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("slot", 32'(want.slot), 32'(got.slot));
                check_field("moved", 32'(want.moved), 32'(got.moved));
                check_field("moved_from", 32'(want.moved_from), 32'(got.moved_from));
                check_field("count", 32'(want.count), 32'(got.count));
                check_field("zero fill", 32'd0, 32'(m_tdata >> RESULT_W));
            end
        end
    end

    // Ends the run when nothing has been accepted on either side for too long.
    int stuck_cycles = 0;

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stuck_cycles <= 0;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_sparse_set_table: done, errors");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_basic_commands();
        test_output_backpressure();
        test_fill_and_drain();
        test_random_mix();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_sparse_set_table: done, clean");
        else
            $display("tb_sparse_set_table: done, errors");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/sst_pkg.sv
hw/rtl/sst_ram.sv
hw/rtl/sparse_set_table.sv
hw/rtl/sst_checker.sv
tb/tb_sparse_set_table.sv
